### hdl/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg
// Shared constants, codes and helpers for the multilevel queue scheduler.
// ----------------------------------------------------------------------------
package msq_pkg;

  // Default sizing
  localparam int DEF_LEVEL_DEPTH = 1024;
  localparam int DEF_TAG_BITS    = 16;
  localparam int DEF_TIME_BITS   = 32;

  localparam int NUM_LEVELS = 4;
  localparam int PRI_BITS   = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PROMO_W    = 11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASEQ  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STARVE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 3'd4;

  // Configuration reset values
  localparam logic [20:0] RST_THRESH = 21'd185542;
  localparam logic [31:0] RST_BASEQ  = 32'd118629180;
  localparam logic [31:0] RST_BOOST  = 32'd185405204;
  localparam logic [63:0] RST_STARVE = 64'd84443437912555600;
  localparam logic [63:0] RST_SIZE   = 64'd168886875830354090;

  // Item kinds
  localparam logic KIND_ENQ   = 1'b0;
  localparam logic KIND_SERVE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ENQ    = 2'd0;
  localparam logic [1:0] ST_DROP   = 2'd1;
  localparam logic [1:0] ST_SERVED = 2'd2;
  localparam logic [1:0] ST_IDLE   = 2'd3;

  // x / 3 by reciprocal multiply, exact for x < 2^17
  function automatic logic [15:0] div3(input logic [16:0] x);
    logic [33:0] p;
    p = 34'(x) * 34'd43691;
    return p[32:17];
  endfunction

endpackage

### hdl/msq_if.sv
// ----------------------------------------------------------------------------
// msq_in_if / msq_out_if
// Valid/ready channels for scheduler requests and results.
// ----------------------------------------------------------------------------
interface msq_in_if #(
  parameter int TAG_BITS = 16
) ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [TAG_BITS-1:0] packet_tag;
  logic [6:0]          priority_req;

  modport source (output valid, kind, packet_tag, priority_req, input ready);
  modport sink   (input valid, kind, packet_tag, priority_req, output ready);
endinterface

interface msq_out_if #(
  parameter int TAG_BITS = 16
) ();
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [TAG_BITS-1:0] served_tag;
  logic [6:0]          served_priority;
  logic [1:0]          served_level;
  logic [10:0]         promoted_count;

  modport source (output valid, status, served_tag, served_priority, served_level,
                  promoted_count, input ready);
  modport sink   (input valid, status, served_tag, served_priority, served_level,
                  promoted_count, output ready);
endinterface

### hdl/msq_mem.sv
// ----------------------------------------------------------------------------
// msq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module msq_mem #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 55
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hdl/multilevel_queue_scheduler_with_aging_unit.sv
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler_with_aging_unit
// Four-level FIFO packet scheduler with quantum turns and aging promotion.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        kind, packet_tag, priority_req
//   out_ch   out  valid/ready        status, served_tag, served_priority,
//                                    served_level, promoted_count
//   cfg      in   cfg_we_i (no wait) cfg_idx_i, cfg_data_i
//
// Enqueue, drop and idle go from S_IDLE to S_DONE; a serve inside a turn passes S_POP between them.
// A turn end on a lower level adds the binary search, S_BSRD and S_BSCMP per probe,
// then, with aged entries, promotion arithmetic in S_CALC and S_CALC2 and an S_MOVERD
// and S_MOVEWR pair per promoted entry; closing the turn adds S_FIN. The high level skips the
// search. All of it is bound by the single read port of the entry store.
// Reset is asynchronous; the entry store needs no clearing pass.
// A stalled result waits in the output register; the next item is taken
// meanwhile and its result waits for that register to drain.
// ----------------------------------------------------------------------------
module multilevel_queue_scheduler_with_aging_unit
  import msq_pkg::*;
#(
  parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
  parameter int TAG_BITS    = DEF_TAG_BITS,
  parameter int TIME_BITS   = DEF_TIME_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  msq_in_if.sink                in_ch,
  msq_out_if.source             out_ch
);

  localparam int D     = LEVEL_DEPTH;
  localparam int IDX_W = $clog2(D);
  localparam int CNT_W = $clog2(D + 1);
  localparam int AW    = $clog2(4 * D);
  localparam int EW    = TAG_BITS + PRI_BITS + TIME_BITS;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_POP    = 4'd1;
  localparam logic [3:0] S_BSRD   = 4'd2;
  localparam logic [3:0] S_BSCMP  = 4'd3;
  localparam logic [3:0] S_CALC   = 4'd4;
  localparam logic [3:0] S_CALC2  = 4'd5;
  localparam logic [3:0] S_MOVERD = 4'd6;
  localparam logic [3:0] S_MOVEWR = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  function automatic logic [AW-1:0] f_addr(input logic [1:0] lv,
                                           input logic [IDX_W-1:0] idx);
    return AW'(lv) * AW'(D) + AW'(idx);
  endfunction

  function automatic logic [IDX_W-1:0] f_wrap(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
    if (s >= (CNT_W+1)'(D)) begin
      s = s - (CNT_W+1)'(D);
    end
    return s[IDX_W-1:0];
  endfunction

  // configuration
  logic [20:0] thr_q;
  logic [31:0] bq_q, qb_q;
  logic [63:0] sl_q, sz_q;

  // level state
  logic [IDX_W-1:0] head_q [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_q  [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] starved_q;
  logic [1:0]           cur_q;
  logic [8:0]           qleft_q;
  logic [TIME_BITS-1:0] tick_q;

  // sequencer
  logic [3:0]       state_q;
  logic [1:0]       lv_q;
  logic [CNT_W-1:0] lo_q, hp1_q, mid_q, n_q, moved_q, mv_q;
  logic [16:0]      wanted_q;
  logic [15:0]      sp3_q;

  // pending result
  logic [1:0]          res_status_q, res_lvl_q;
  logic [TAG_BITS-1:0] res_tag_q;
  logic [6:0]          res_pri_q;
  logic [10:0]         res_promo_q;

  // output register
  logic                out_valid_q;
  logic [1:0]          out_status_q, out_lvl_q;
  logic [TAG_BITS-1:0] out_tag_q;
  logic [6:0]          out_pri_q;
  logic [10:0]         out_promo_q;

  // memory ports
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  logic [TAG_BITS-1:0]  rd_tag;
  logic [6:0]           rd_pri;
  logic [TIME_BITS-1:0] rd_stamp;
  assign rd_tag   = mem_rdata[EW-1 -: TAG_BITS];
  assign rd_pri   = mem_rdata[TIME_BITS +: PRI_BITS];
  assign rd_stamp = mem_rdata[TIME_BITS-1:0];

  logic in_fire, out_free;
  assign in_ch.ready = (state_q == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_q || out_ch.ready;

  // enqueue level by thresholds
  logic [1:0] enq_lv;
  always_comb begin
    if (in_ch.priority_req >= thr_q[6:0]) begin
      enq_lv = 2'd0;
    end else if (in_ch.priority_req >= thr_q[13:7]) begin
      enq_lv = 2'd1;
    end else if (in_ch.priority_req >= thr_q[20:14]) begin
      enq_lv = 2'd2;
    end else begin
      enq_lv = 2'd3;
    end
  end

  // serve level pick and new quantum
  logic       need_new, srv_ok;
  logic [1:0] srv_lv, scan_lv;
  logic [8:0] new_q;
  always_comb begin
    need_new = (qleft_q == 9'd0) || (cnt_q[cur_q] == '0);
    srv_ok   = !need_new;
    srv_lv   = cur_q;
    if (need_new) begin
      for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
        scan_lv = cur_q + 2'(k);
        if (cnt_q[scan_lv] != '0) begin
          srv_lv = scan_lv;
          srv_ok = 1'b1;
        end
      end
    end
    scan_lv = srv_lv;
    new_q = {1'b0, bq_q[{srv_lv, 3'b000} +: 8]};
    if ((17'(cnt_q[srv_lv]) > 17'(sz_q[{srv_lv, 4'b0000} +: 16])) || starved_q[srv_lv]) begin
      new_q = new_q + {1'b0, qb_q[{srv_lv, 3'b000} +: 8]};
    end
    if (new_q == 9'd0) begin
      new_q = 9'd1;
    end
  end

  // search midpoint and promotion helpers
  logic [1:0]       up_lv;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid_c;
  logic [TIME_BITS-1:0] age;
  logic [15:0]      space;
  logic [16:0]      nm1, room, mcap;
  logic [7:0]       base_lv;
  assign up_lv   = lv_q - 2'd1;
  assign mid_sum = (CNT_W+1)'(lo_q) + (CNT_W+1)'(hp1_q) - (CNT_W+1)'(1);
  assign mid_c   = mid_sum[CNT_W:1];
  assign age     = tick_q - rd_stamp;
  assign base_lv = bq_q[{lv_q, 3'b000} +: 8];
  assign nm1     = 17'(n_q) - 17'd1;
  assign room    = 17'(D) - 17'(cnt_q[up_lv]);
  always_comb begin
    if (17'(sz_q[{up_lv, 4'b0000} +: 16]) > 17'(cnt_q[up_lv])) begin
      space = 16'(17'(sz_q[{up_lv, 4'b0000} +: 16]) - 17'(cnt_q[up_lv]));
    end else begin
      space = 16'd0;
    end
    mcap = (17'(sp3_q) < wanted_q) ? 17'(sp3_q) : wanted_q;
    if (mcap > room) begin
      mcap = room;
    end
  end

  // memory access per state; reads and writes never hit one entry together
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = f_addr(enq_lv, f_wrap(head_q[enq_lv], cnt_q[enq_lv]));
    mem_wdata = {in_ch.packet_tag, in_ch.priority_req, tick_q};
    mem_raddr = f_addr(srv_lv, head_q[srv_lv]);
    case (state_q)
      S_IDLE: begin
        if (in_fire && in_ch.kind == KIND_ENQ) begin
          mem_we = (cnt_q[enq_lv] < CNT_W'(D));
        end
        if (in_fire && in_ch.kind == KIND_SERVE) begin
          mem_re = srv_ok;
        end
      end
      S_BSRD: begin
        mem_re    = (lo_q < hp1_q);
        mem_raddr = f_addr(lv_q, f_wrap(head_q[lv_q], mid_c));
      end
      S_MOVERD: begin
        mem_re    = (mv_q < moved_q);
        mem_raddr = f_addr(lv_q, head_q[lv_q]);
      end
      S_MOVEWR: begin
        mem_we    = 1'b1;
        mem_waddr = f_addr(up_lv, f_wrap(head_q[up_lv], cnt_q[up_lv]));
        mem_wdata = {rd_tag, rd_pri, tick_q};
      end
      default: ;
    endcase
  end

  msq_mem #(
    .DEPTH (4 * D),
    .WIDTH (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= RST_THRESH;
      bq_q  <= RST_BASEQ;
      qb_q  <= RST_BOOST;
      sl_q  <= RST_STARVE;
      sz_q  <= RST_SIZE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESH: thr_q <= cfg_data_i[20:0];
        CFG_BASEQ:  bq_q  <= cfg_data_i[31:0];
        CFG_BOOST:  qb_q  <= cfg_data_i[31:0];
        CFG_STARVE: sl_q  <= cfg_data_i;
        CFG_SIZE:   sz_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      starved_q    <= '0;
      cur_q        <= '0;
      qleft_q      <= '0;
      tick_q       <= '0;
      state_q      <= S_IDLE;
      lv_q         <= '0;
      lo_q         <= '0;
      hp1_q        <= '0;
      mid_q        <= '0;
      n_q          <= '0;
      moved_q      <= '0;
      mv_q         <= '0;
      wanted_q     <= '0;
      sp3_q        <= '0;
      res_status_q <= ST_IDLE;
      res_tag_q    <= '0;
      res_pri_q    <= '0;
      res_lvl_q    <= '0;
      res_promo_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_IDLE;
      out_tag_q    <= '0;
      out_pri_q    <= '0;
      out_lvl_q    <= '0;
      out_promo_q  <= '0;
    end else begin
      // drained result; a reload in S_DONE keeps it valid instead
      if (out_valid_q && out_ch.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            res_tag_q   <= '0;
            res_pri_q   <= '0;
            res_lvl_q   <= '0;
            res_promo_q <= '0;
            state_q     <= S_DONE;
            if (in_ch.kind == KIND_ENQ) begin
              if (cnt_q[enq_lv] < CNT_W'(D)) begin
                cnt_q[enq_lv] <= cnt_q[enq_lv] + CNT_W'(1);
                res_status_q  <= ST_ENQ;
              end else begin
                res_status_q <= ST_DROP;
              end
            end else if (!srv_ok) begin
              res_status_q <= ST_IDLE;
            end else begin
              cur_q   <= srv_lv;
              lv_q    <= srv_lv;
              state_q <= S_POP;
              if (need_new) begin
                qleft_q <= new_q;
              end
            end
          end
        end
        S_POP: begin
          res_status_q   <= ST_SERVED;
          res_tag_q      <= rd_tag;
          res_pri_q      <= rd_pri;
          res_lvl_q      <= lv_q;
          head_q[lv_q]   <= f_wrap(head_q[lv_q], CNT_W'(1));
          cnt_q[lv_q]    <= cnt_q[lv_q] - CNT_W'(1);
          qleft_q        <= qleft_q - 9'd1;
          tick_q         <= tick_q + TIME_BITS'(1);
          n_q            <= '0;
          moved_q        <= '0;
          lo_q           <= '0;
          hp1_q          <= cnt_q[lv_q] - CNT_W'(1);
          if (qleft_q == 9'd1 || cnt_q[lv_q] == CNT_W'(1)) begin
            state_q <= (lv_q == 2'd0) ? S_FIN : S_BSRD;
          end else begin
            state_q <= S_DONE;
          end
        end
        // binary search for the last aged entry
        S_BSRD: begin
          mid_q <= mid_c;
          if (lo_q < hp1_q) begin
            state_q <= S_BSCMP;
          end else begin
            state_q <= (n_q == '0) ? S_FIN : S_CALC;
          end
        end
        S_BSCMP: begin
          if (age >= TIME_BITS'(sl_q[{lv_q, 4'b0000} +: 16])) begin
            n_q  <= mid_q + CNT_W'(1);
            lo_q <= mid_q + CNT_W'(1);
          end else begin
            hp1_q <= mid_q;
          end
          state_q <= S_BSRD;
        end
        // promotion amount
        S_CALC: begin
          sp3_q <= div3({1'b0, space});
          if (17'(base_lv) < 17'(n_q)) begin
            wanted_q <= 17'(n_q) - 17'(base_lv);
          end else begin
            wanted_q <= 17'(div3(nm1));
          end
          state_q <= S_CALC2;
        end
        S_CALC2: begin
          moved_q <= CNT_W'(mcap);
          mv_q    <= '0;
          state_q <= S_MOVERD;
        end
        // move aged entries up one level
        S_MOVERD: begin
          state_q <= (mv_q < moved_q) ? S_MOVEWR : S_FIN;
        end
        S_MOVEWR: begin
          head_q[lv_q] <= f_wrap(head_q[lv_q], CNT_W'(1));
          cnt_q[lv_q]  <= cnt_q[lv_q] - CNT_W'(1);
          cnt_q[up_lv] <= cnt_q[up_lv] + CNT_W'(1);
          mv_q         <= mv_q + CNT_W'(1);
          state_q      <= S_MOVERD;
        end
        S_FIN: begin
          if (n_q != '0 && lv_q != 2'd0) begin
            if (wanted_q > 17'(moved_q)) begin
              starved_q[lv_q] <= 1'b1;
            end
          end else begin
            starved_q[lv_q] <= 1'b0;
          end
          cur_q       <= lv_q + 2'd1;
          qleft_q     <= 9'd0;
          res_promo_q <= 11'(moved_q);
          state_q     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_tag_q    <= res_tag_q;
            out_pri_q    <= res_pri_q;
            out_lvl_q    <= res_lvl_q;
            out_promo_q  <= res_promo_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.status          = out_status_q;
  assign out_ch.served_tag      = out_tag_q;
  assign out_ch.served_priority = out_pri_q;
  assign out_ch.served_level    = out_lvl_q;
  assign out_ch.promoted_count  = out_promo_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= CNT_W'(D) && cnt_q[1] <= CNT_W'(D) &&
    cnt_q[2] <= CNT_W'(D) && cnt_q[3] <= CNT_W'(D))
    else $error("level count above depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != S_IDLE)
    else $error("accepted item left no work");

  a_turn_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |=> qleft_q == 9'd0)
    else $error("quantum left after turn end");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re && mem_waddr == mem_raddr))
    else $error("read and write of one entry in one cycle");

endmodule
